>>> rtl/dtbl_pkg.sv
// ----------------------------------------------------------------------------
// Daylight tier backlight control package
// Shared types, register codes, constants and level helpers for the block.
// ----------------------------------------------------------------------------
package dtbl_pkg;

    localparam int unsigned NOW_W   = 32;
    localparam int unsigned IDLE_W  = 32;
    localparam int unsigned ALT_W   = 15;
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned THR_W   = 16;
    localparam int unsigned DIM_THR_W = 26;

    localparam logic [NOW_W-1:0]   EVAL_PERIOD_MS = 32'd15000;
    localparam logic [THR_W-1:0]   HYST_CENTI     = 16'd200;
    localparam logic [DIM_THR_W-1:0] MS_PER_SEC   = 26'd1000;
    localparam logic [LEVEL_W-1:0] DAY_LEVEL      = 8'd255;
    localparam logic [LEVEL_W-1:0] MIN_BASE       = 8'd10;
    localparam logic [LEVEL_W-1:0] MIN_DIM        = 8'd5;

    typedef enum logic [1:0] {
        TIER_DAY   = 2'd0,
        TIER_NIGHT = 2'd1,
        TIER_RED   = 2'd2
    } tier_t;

    typedef enum logic [1:0] {
        MODE_AUTO  = 2'd0,
        MODE_DAY   = 2'd1,
        MODE_NIGHT = 2'd2
    } mode_t;

    typedef logic [CFG_INDEX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_THEME_MODE   = 3'd0;
    localparam cfg_idx_t CFG_RED_PALETTE  = 3'd1;
    localparam cfg_idx_t CFG_NIGHT_ALT    = 3'd2;
    localparam cfg_idx_t CFG_RED_ALT      = 3'd3;
    localparam cfg_idx_t CFG_DIM_AFTER    = 3'd4;
    localparam cfg_idx_t CFG_DIM_LEVEL    = 3'd5;
    localparam cfg_idx_t CFG_NIGHT_BL     = 3'd6;
    localparam cfg_idx_t CFG_FORCED_BL    = 3'd7;

    typedef struct packed {
        logic [1:0]         theme_mode;
        logic               red_palette;
        logic signed [7:0]  night_alt_deg;
        logic signed [7:0]  red_alt_deg;
        logic [15:0]        dim_after_sec;
        logic [LEVEL_W-1:0] dim_level;
        logic [LEVEL_W-1:0] night_backlight;
        logic [LEVEL_W-1:0] forced_backlight;
    } cfg_t;

    typedef struct packed {
        logic [NOW_W-1:0]        now_ms;
        logic [IDLE_W-1:0]       idle_ms;
        logic signed [ALT_W-1:0] sun_alt;
        logic                    sun_valid;
    } item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] backlight;
        logic               backlight_written;
        tier_t              tier;
        logic               red_theme;
    } result_t;

    // Base level that a tier apply sets, overrides included.
    function automatic logic [LEVEL_W-1:0] tier_base(input tier_t t,
                                                     input cfg_t c);
        logic [LEVEL_W-1:0] lvl;
        begin
            if (t == TIER_DAY)
            begin
                lvl = DAY_LEVEL;
            end
            else
            begin
                lvl = (c.night_backlight < MIN_BASE) ? MIN_BASE : c.night_backlight;
            end
            if (c.forced_backlight != '0)
            begin
                lvl = (c.forced_backlight < MIN_BASE) ? MIN_BASE : c.forced_backlight;
            end
            return lvl;
        end
    endfunction

    // Altitude threshold in hundredths of a degree, optionally raised.
    function automatic logic signed [THR_W-1:0] alt_thr(input logic signed [7:0] deg,
                                                        input logic hyst);
        logic signed [THR_W-1:0] thr;
        begin
            thr = THR_W'(deg) * $signed(16'd100);
            if (hyst)
            begin
                thr = thr + $signed(HYST_CENTI);
            end
            return thr;
        end
    endfunction

endpackage

>>> rtl/daylight_tier_backlight_control_top.sv
// ----------------------------------------------------------------------------
// Daylight tier backlight control
// Top level: tick input register, tier core, result register, config port.
// ----------------------------------------------------------------------------
// Each tick request carries the time, the idle time and the sun altitude in
// hundredths of a degree, and yields exactly one result request with the
// backlight level in force, whether the backlight was rewritten, the tier
// (day, night or red) and the red theme flag. A tick is held in the input
// register and then passes through the combinational core into the result
// register, which holds the result until the result side accepts it. The
// tier state is updated by a single pass of compare and clamp logic, so a
// new tick can be taken in every cycle while the result side keeps up; the
// input stalls only while both registers are full and the result side is
// stalling. The first tick after reset applies the day tier before anything
// else. A tier is chosen at most once every 15000 ms of tick time, forced by
// the theme mode or, in auto mode, from altitude thresholds with 2 degrees of
// hysteresis when brightening; in auto mode an invalid sun input gives day.
// Configuration writes are always ready and should only be made while no
// tick is in flight.
// ----------------------------------------------------------------------------
module daylight_tier_backlight_control_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  dtbl_pkg::cfg_idx_t                  cfg_index,
    input  logic [dtbl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dtbl_pkg::NOW_W-1:0]          now_ms,
    input  logic [dtbl_pkg::IDLE_W-1:0]         idle_ms,
    input  logic signed [dtbl_pkg::ALT_W-1:0]   sun_alt,
    input  logic                                sun_valid,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [dtbl_pkg::LEVEL_W-1:0]        backlight,
    output logic                                backlight_written,
    output logic [1:0]                          tier,
    output logic                                red_theme
);
    import dtbl_pkg::*;

    cfg_t    cfg;
    item_t   item;
    logic    item_valid;
    result_t result;
    logic    can_load;
    logic    advance;

    // The core moves one tick forward whenever the result register can take it.
    assign advance = item_valid && can_load;

    dtbl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dtbl_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .now_ms     (now_ms),
        .idle_ms    (idle_ms),
        .sun_alt    (sun_alt),
        .sun_valid  (sun_valid),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    dtbl_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    dtbl_out_stage u_out (
        .clk               (clk),
        .rst_n             (rst_n),
        .load              (advance),
        .result            (result),
        .can_load          (can_load),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .backlight         (backlight),
        .backlight_written (backlight_written),
        .tier              (tier),
        .red_theme         (red_theme)
    );

    // The red theme flag always follows the tier it is reported with.
    a_red_theme: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red_theme == (tier == TIER_RED)))
        else $error("red theme flag disagrees with tier");

    // No level below the dimming floor is ever reported.
    a_level_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (backlight >= MIN_DIM))
        else $error("backlight below minimum level");

    // The input may only stall while a tick is held and the result ahead of it is blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (item_valid && out_valid && out_stall))
        else $error("input stalled without a blocked result");

    // A tick taken by the core always lands in the result register.
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("advanced tick did not produce a result");

endmodule

>>> rtl/dtbl_cfg.sv
// ----------------------------------------------------------------------------
// Configuration register file
// Holds the eight control registers and takes one write a cycle.
// ----------------------------------------------------------------------------
module dtbl_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  dtbl_pkg::cfg_idx_t             cfg_index,
    input  logic [dtbl_pkg::CFG_DATA_W-1:0] cfg_data,
    output dtbl_pkg::cfg_t                 cfg
);
    import dtbl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_THEME_MODE:  cfg_next.theme_mode       = cfg_data[1:0];
                CFG_RED_PALETTE: cfg_next.red_palette      = cfg_data[0];
                CFG_NIGHT_ALT:   cfg_next.night_alt_deg    = $signed(cfg_data[7:0]);
                CFG_RED_ALT:     cfg_next.red_alt_deg      = $signed(cfg_data[7:0]);
                CFG_DIM_AFTER:   cfg_next.dim_after_sec    = cfg_data[15:0];
                CFG_DIM_LEVEL:   cfg_next.dim_level        = cfg_data[7:0];
                CFG_NIGHT_BL:    cfg_next.night_backlight  = cfg_data[7:0];
                CFG_FORCED_BL:   cfg_next.forced_backlight = cfg_data[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.theme_mode       <= MODE_AUTO;
            cfg_reg.red_palette      <= 1'b0;
            cfg_reg.night_alt_deg    <= -8'sd6;
            cfg_reg.red_alt_deg      <= -8'sd12;
            cfg_reg.dim_after_sec    <= 16'd120;
            cfg_reg.dim_level        <= 8'd20;
            cfg_reg.night_backlight  <= 8'd90;
            cfg_reg.forced_backlight <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/dtbl_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one tick request and holds it until the core takes it.
// ----------------------------------------------------------------------------
module dtbl_in_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dtbl_pkg::NOW_W-1:0]          now_ms,
    input  logic [dtbl_pkg::IDLE_W-1:0]         idle_ms,
    input  logic signed [dtbl_pkg::ALT_W-1:0]   sun_alt,
    input  logic                                sun_valid,
    input  logic                                take,
    output logic                                item_valid,
    output dtbl_pkg::item_t                     item
);
    import dtbl_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // The register frees up in the same cycle that the core takes it.
    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && !take);
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.now_ms    <= now_ms;
            item_reg.idle_ms   <= idle_ms;
            item_reg.sun_alt   <= sun_alt;
            item_reg.sun_valid <= sun_valid;
        end
    end

endmodule

>>> rtl/dtbl_core.sv
// ----------------------------------------------------------------------------
// Tier and dimming core
// Holds the tier state and works out one tick's result combinationally.
// ----------------------------------------------------------------------------
module dtbl_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  dtbl_pkg::item_t   item,
    input  dtbl_pkg::cfg_t    cfg,
    output dtbl_pkg::result_t result
);
    import dtbl_pkg::*;

    tier_t                tier_reg;
    tier_t                tier_next;
    logic                 applied_reg;
    logic [LEVEL_W-1:0]   base_reg;
    logic [LEVEL_W-1:0]   base_next;
    logic [LEVEL_W-1:0]   cur_reg;
    logic [LEVEL_W-1:0]   cur_next;
    logic [NOW_W-1:0]     last_eval_reg;
    logic [NOW_W-1:0]     last_eval_next;

    tier_t                tier1;
    logic [LEVEL_W-1:0]   base1;
    logic [LEVEL_W-1:0]   cur1;
    logic [LEVEL_W-1:0]   dim_clamped;
    logic [LEVEL_W-1:0]   target;
    logic [DIM_THR_W-1:0] dim_thr;
    logic                 dimming;
    logic [NOW_W-1:0]     since;
    logic                 eval;
    logic signed [THR_W-1:0] alt;
    logic signed [THR_W-1:0] day_thr;
    logic signed [THR_W-1:0] red_thr;
    tier_t                auto_tier;
    tier_t                chosen;
    logic                 change;
    logic                 written;

    // Power-up apply of the day tier is folded into the first tick.
    always_comb
    begin
        if (applied_reg)
        begin
            tier1 = tier_reg;
            base1 = base_reg;
            cur1  = cur_reg;
        end
        else
        begin
            tier1 = TIER_DAY;
            base1 = tier_base(TIER_DAY, cfg);
            cur1  = base1;
        end
    end

    // Idle dimming.
    assign dim_thr = DIM_THR_W'(cfg.dim_after_sec) * MS_PER_SEC;
    assign dimming = item.idle_ms > IDLE_W'(dim_thr);

    always_comb
    begin
        if (cfg.dim_level < MIN_DIM)
        begin
            dim_clamped = MIN_DIM;
        end
        else if (cfg.dim_level > base1)
        begin
            dim_clamped = base1;
        end
        else
        begin
            dim_clamped = cfg.dim_level;
        end
        target = dimming ? dim_clamped : base1;
    end

    // Evaluation gate against the wrapping millisecond clock.
    assign since = item.now_ms - last_eval_reg;
    assign eval  = since >= EVAL_PERIOD_MS;

    // Auto tier from the sun altitude, with hysteresis when brightening.
    assign alt     = THR_W'(item.sun_alt);
    assign day_thr = alt_thr(cfg.night_alt_deg, tier1 != TIER_DAY);
    assign red_thr = alt_thr(cfg.red_alt_deg, tier1 == TIER_RED);

    always_comb
    begin
        if (alt >= day_thr)
        begin
            auto_tier = TIER_DAY;
        end
        else if (alt >= red_thr || !cfg.red_palette)
        begin
            auto_tier = TIER_NIGHT;
        end
        else
        begin
            auto_tier = TIER_RED;
        end

        case (cfg.theme_mode)
            MODE_DAY:   chosen = TIER_DAY;
            MODE_NIGHT: chosen = cfg.red_palette ? TIER_RED : TIER_NIGHT;
            default:    chosen = item.sun_valid ? auto_tier : TIER_DAY;
        endcase
    end

    assign change = eval && (chosen != tier1);

    always_comb
    begin
        tier_next      = tier1;
        base_next      = base1;
        cur_next       = target;
        written        = !applied_reg || (target != cur1);
        last_eval_next = eval ? item.now_ms : last_eval_reg;
        if (change)
        begin
            tier_next = chosen;
            base_next = tier_base(chosen, cfg);
            cur_next  = base_next;
            written   = 1'b1;
        end
        result.backlight         = cur_next;
        result.backlight_written = written;
        result.tier              = tier_next;
        result.red_theme         = (tier_next == TIER_RED);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tier_reg      <= TIER_DAY;
            applied_reg   <= 1'b0;
            base_reg      <= DAY_LEVEL;
            cur_reg       <= DAY_LEVEL;
            last_eval_reg <= '0;
        end
        else if (advance)
        begin
            tier_reg      <= tier_next;
            applied_reg   <= 1'b1;
            base_reg      <= base_next;
            cur_reg       <= cur_next;
            last_eval_reg <= last_eval_next;
        end
    end

endmodule

>>> rtl/dtbl_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the receiving side takes it.
// ----------------------------------------------------------------------------
module dtbl_out_stage (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  dtbl_pkg::result_t            result,
    output logic                         can_load,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [dtbl_pkg::LEVEL_W-1:0] backlight,
    output logic                         backlight_written,
    output logic [1:0]                   tier,
    output logic                         red_theme
);
    import dtbl_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load   = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);

    assign out_valid         = valid_reg;
    assign backlight         = res_reg.backlight;
    assign backlight_written = res_reg.backlight_written;
    assign tier              = res_reg.tier;
    assign red_theme         = res_reg.red_theme;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

endmodule
